// ===== sv/gfts_pkg.sv =====
// ----------------------------------------------------------------------------
// GNSS fix tracker package
// Shared types, constants and the month length table.
// ----------------------------------------------------------------------------
package gfts_pkg;

  localparam int unsigned InW  = 184;
  localparam int unsigned OutW = 208;

  localparam logic [31:0] RESET_BASE_SECONDS = 32'd1754006400;
  localparam logic [3:0]  RESET_BASE_MONTH   = 4'd8;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  // ceil(2^26 / 1000); exact for every 16-bit millisecond count.
  localparam logic [16:0] MS_RECIP = 17'd67109;

  localparam logic [1:0] CFG_BASE_SECONDS = 2'd0;
  localparam logic [1:0] CFG_BASE_MONTH   = 2'd1;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_NOFIX  = 2'd1,
    MODE_SAMPLE = 2'd2,
    MODE_HELD   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACC,
    OP_DAYS,
    OP_MULD,
    OP_HOUR,
    OP_MIN,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   msec_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic held;
    logic acc_done;
  } dp_status_t;

  // Non-leap month length; months outside one to twelve count zero days.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/gfts_ctrl.sv =====
// ----------------------------------------------------------------------------
// GNSS fix tracker controller
// Sequences a report: load, then month accumulation and timestamp if held.
// ----------------------------------------------------------------------------
module gfts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  gfts_pkg::dp_status_t status_i,
  output gfts_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DAYS,
    S_MULD,
    S_HOUR,
    S_MIN,
    S_MSEC,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.op      = gfts_pkg::OP_NONE;
    cmd_o.msec_wr = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = gfts_pkg::OP_LOAD;
          state_d  = status_i.held ? S_ACC : S_FIN;
        end
      end
      S_ACC: begin
        if (status_i.acc_done) begin
          state_d = S_DAYS;
        end else begin
          cmd_o.op = gfts_pkg::OP_ACC;
        end
      end
      S_DAYS: begin
        cmd_o.op = gfts_pkg::OP_DAYS;
        state_d  = S_MULD;
      end
      S_MULD: begin
        cmd_o.op = gfts_pkg::OP_MULD;
        state_d  = S_HOUR;
      end
      S_HOUR: begin
        cmd_o.op = gfts_pkg::OP_HOUR;
        state_d  = S_MIN;
      end
      S_MIN: begin
        cmd_o.op = gfts_pkg::OP_MIN;
        state_d  = S_MSEC;
      end
      S_MSEC: begin
        cmd_o.msec_wr = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        // The result register may still hold the previous transaction.
        if (out_free) begin
          cmd_o.op    = gfts_pkg::OP_FIN;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/gfts_dp.sv =====
// ----------------------------------------------------------------------------
// GNSS fix tracker datapath
// Mode, PPS captures, configuration, timestamp arithmetic and result register.
// ----------------------------------------------------------------------------
module gfts_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic [gfts_pkg::InW-1:0]      in_data_i,
  input  gfts_pkg::dp_cmd_t             cmd_i,
  output gfts_pkg::dp_status_t          status_o,
  output logic [gfts_pkg::OutW-1:0]     out_data_o
);

  // Configuration
  logic [31:0] base_seconds_q;
  logic [3:0]  base_month_q;

  // Block state
  gfts_pkg::mode_e mode_q, mode_d;
  logic [31:0]     timestamp_q;
  logic [31:0]     pps_now_q;
  logic [31:0]     pps_before_q;

  // Per-report payload
  logic        report_q;
  logic [38:0] lon_q;
  logic [37:0] lat_q;
  logic [31:0] alt_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [15:0] msec_q;

  // Working registers
  logic [3:0]  m_q;
  logic [8:0]  acc_q;
  logic [31:0] work_q;

  logic [gfts_pkg::OutW-1:0] out_q;

  logic        fix, hold, report_d;
  logic [48:0] day_prod;
  logic [16:0] hour_prod;
  logic [11:0] min_prod;
  logic [32:0] ms_prod;

  assign fix  = in_data_i[0];
  assign hold = in_data_i[1];

  always_comb begin
    mode_d   = mode_q;
    report_d = 1'b0;
    case (mode_q)
      gfts_pkg::MODE_INIT:   mode_d = fix ? gfts_pkg::MODE_SAMPLE : gfts_pkg::MODE_NOFIX;
      gfts_pkg::MODE_NOFIX:  if (fix) mode_d = gfts_pkg::MODE_SAMPLE;
      gfts_pkg::MODE_SAMPLE: begin
        if (hold) begin
          mode_d   = gfts_pkg::MODE_HELD;
          report_d = 1'b1;
        end
      end
      default:               mode_d = mode_q;
    endcase
  end

  assign status_o.held     = (mode_q == gfts_pkg::MODE_HELD);
  assign status_o.acc_done = (m_q >= month_q);

  assign day_prod  = work_q * gfts_pkg::SECS_PER_DAY;
  assign hour_prod = hour_q * gfts_pkg::SECS_PER_HOUR;
  assign min_prod  = minute_q * gfts_pkg::SECS_PER_MIN;
  assign ms_prod   = msec_q * gfts_pkg::MS_RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_seconds_q <= gfts_pkg::RESET_BASE_SECONDS;
      base_month_q   <= gfts_pkg::RESET_BASE_MONTH;
      mode_q         <= gfts_pkg::MODE_INIT;
      timestamp_q    <= gfts_pkg::RESET_BASE_SECONDS;
      pps_now_q      <= 32'd0;
      pps_before_q   <= 32'd0;
    end else begin
      if (cfg_valid_i && cfg_index_i == gfts_pkg::CFG_BASE_SECONDS) begin
        base_seconds_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == gfts_pkg::CFG_BASE_MONTH) begin
        base_month_q <= cfg_data_i[3:0];
      end
      if (cmd_i.op == gfts_pkg::OP_LOAD) begin
        mode_q       <= mode_d;
        pps_before_q <= pps_now_q;
        pps_now_q    <= in_data_i[178:147];
      end
      if (cmd_i.msec_wr) begin
        timestamp_q <= work_q + {25'd0, ms_prod[32:26]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      gfts_pkg::OP_LOAD: begin
        report_q <= report_d;
        lon_q    <= report_d ? in_data_i[40:2]   : 39'd0;
        lat_q    <= report_d ? in_data_i[78:41]  : 38'd0;
        alt_q    <= report_d ? in_data_i[110:79] : 32'd0;
        month_q  <= in_data_i[114:111];
        day_q    <= in_data_i[119:115];
        hour_q   <= in_data_i[124:120];
        minute_q <= in_data_i[130:125];
        msec_q   <= in_data_i[146:131];
        m_q      <= base_month_q;
        acc_q    <= 9'd0;
      end
      gfts_pkg::OP_ACC: begin
        acc_q <= acc_q + {4'd0, gfts_pkg::month_len(m_q)};
        m_q   <= m_q + 4'd1;
      end
      gfts_pkg::OP_DAYS: work_q <= {23'd0, acc_q} + {27'd0, day_q} - 32'd1;
      gfts_pkg::OP_MULD: work_q <= base_seconds_q + day_prod[31:0];
      gfts_pkg::OP_HOUR: work_q <= work_q + {15'd0, hour_prod};
      gfts_pkg::OP_MIN:  work_q <= work_q + {20'd0, min_prod};
      gfts_pkg::OP_FIN: begin
        out_q <= {pps_before_q, pps_now_q, timestamp_q, alt_q, lat_q, lon_q,
                  report_q, mode_q};
      end
      default: begin
      end
    endcase
  end

  assign out_data_o = out_q;

endmodule

// ===== sv/gnss_fix_tracker_utc_stamper.sv =====
// ----------------------------------------------------------------------------
// GNSS fix tracker and UTC stamper
// Tracks the fix mode, PPS captures and a seconds timestamp per receiver report.
// ----------------------------------------------------------------------------
// In position held a report runs the month loop, which adds one month length
// per cycle, before the day, multiply, hour, minute and millisecond steps.
// One report is worked on at a time; the next may be accepted while the
// previous result waits on the output register.
// Reset (asynchronous, active low) restores mode init, zero PPS captures, the
// default configuration and the default timestamp; no clearing pass is needed.
module gnss_fix_tracker_utc_stamper (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [31:0]               cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // fix_valid, position_hold, longitude, latitude, altitude, utc_month,
  // utc_day, utc_hour, utc_minute, utc_millisecond, pps_capture, zero pad
  input  logic [gfts_pkg::InW-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // fix_mode, position_report, held_longitude, held_latitude, held_altitude,
  // utc_seconds, pps_latest, pps_previous
  output logic [gfts_pkg::OutW-1:0] m_axis_tdata
);

  gfts_pkg::dp_cmd_t    cmd;
  gfts_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  gfts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gfts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata)
  );

  // One report at a time: the input side closes right after a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a report is in work");

  // A position is reported only on entry to position held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == gfts_pkg::MODE_HELD)
    else $error("position report outside position held");

  // Without a report the position fields are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[111:3] == '0)
    else $error("position fields set without a report");

  // A command issued in the last state is always followed by a presented result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == gfts_pkg::OP_FIN |=> m_axis_tvalid)
    else $error("finished report not presented");

endmodule

// ===== verif/tb_gnss_fix_tracker_utc_stamper.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GNSS fix tracker and UTC stamper testbench
// Drives receiver reports through the stream input with random gaps. The
// testbench tracks the fix mode, the PPS captures and the seconds timestamp
// on its own and checks every result field against that tracked state.
// Configuration is rewritten between phases, with the block idle.
// ----------------------------------------------------------------------------
module tb_gnss_fix_tracker_utc_stamper;

  // These register indexes decode to nothing in the block.
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned MAX_WAIT    = 10;
  localparam int unsigned SETTLE      = 40;

  // Fields from the lowest bit up: fix, hold, lon, lat, alt, month, day,
  // hour, minute, msec, pps, zero pad.
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] pps;
    logic [15:0] msec;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [31:0] alt;
    logic [37:0] lat;
    logic [38:0] lon;
    logic        hold;
    logic        fix;
  } gnss_report_t;

  // Fields from the lowest bit up: mode, report, lon, lat, alt, seconds,
  // latest capture, previous capture.
  typedef struct packed {
    logic [31:0] pps_prev;
    logic [31:0] pps_latest;
    logic [31:0] seconds;
    logic [31:0] alt;
    logic [37:0] lat;
    logic [38:0] lon;
    logic        report;
    logic [1:0]  mode;
  } fix_result_t;

  localparam int unsigned NONLEAP_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [1:0]                cfg_index_i   = '0;
  logic [31:0]               cfg_data_i    = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [gfts_pkg::InW-1:0]  s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [gfts_pkg::OutW-1:0] m_axis_tdata;

  gnss_fix_tracker_utc_stamper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  gnss_report_t report_q [$];
  fix_result_t  fix_result_q [$];
  int unsigned  mismatch_cnt = 0;

  // Tracked copy of the block's state and configuration.
  gfts_pkg::mode_e trk_mode      = gfts_pkg::MODE_INIT;
  logic [31:0]     trk_stamp     = gfts_pkg::RESET_BASE_SECONDS;
  logic [31:0]     trk_pps_now   = '0;
  logic [31:0]     trk_pps_prev  = '0;
  logic [31:0]     trk_base_secs = gfts_pkg::RESET_BASE_SECONDS;
  logic [3:0]      trk_base_mon  = gfts_pkg::RESET_BASE_MONTH;

  function automatic fix_result_t track_fix(input gnss_report_t rep);
    fix_result_t res;
    logic [31:0] month_days;
    logic [31:0] days;
    logic [31:0] secs;
    res = '0;
    trk_pps_prev = trk_pps_now;
    trk_pps_now  = rep.pps;
    case (trk_mode)
      gfts_pkg::MODE_INIT: begin
        trk_mode = rep.fix ? gfts_pkg::MODE_SAMPLE : gfts_pkg::MODE_NOFIX;
      end
      gfts_pkg::MODE_NOFIX: begin
        if (rep.fix) trk_mode = gfts_pkg::MODE_SAMPLE;
      end
      gfts_pkg::MODE_SAMPLE: begin
        if (rep.hold) begin
          res.report = 1'b1;
          res.lon    = rep.lon;
          res.lat    = rep.lat;
          res.alt    = rep.alt;
          trk_mode   = gfts_pkg::MODE_HELD;
        end
      end
      default: begin
        // Months outside one to twelve never fall in the table, so they add
        // nothing even when they lie inside the accumulation range.
        month_days = '0;
        for (int m = 1; m <= 12; m++) begin
          if (m >= int'(trk_base_mon) && m < int'(rep.month))
            month_days += NONLEAP_DAYS[m-1];
        end
        days = month_days + 32'(rep.day) - 32'd1;
        secs = trk_base_secs;
        secs += days * 32'd86400;
        secs += 32'(rep.hour) * 32'd3600;
        secs += 32'(rep.minute) * 32'd60;
        secs += 32'(rep.msec) / 32'd1000;
        trk_stamp = secs;
      end
    endcase
    res.mode       = trk_mode;
    res.seconds    = trk_stamp;
    res.pps_latest = trk_pps_now;
    res.pps_prev   = trk_pps_prev;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  task automatic check_result(input fix_result_t got, input fix_result_t want);
    if (got.mode !== want.mode)
      flag_mismatch("fix_mode", 64'(got.mode), 64'(want.mode));
    if (got.report !== want.report)
      flag_mismatch("position_report", 64'(got.report), 64'(want.report));
    if (got.lon !== want.lon)
      flag_mismatch("held_longitude", 64'(got.lon), 64'(want.lon));
    if (got.lat !== want.lat)
      flag_mismatch("held_latitude", 64'(got.lat), 64'(want.lat));
    if (got.alt !== want.alt)
      flag_mismatch("held_altitude", 64'(got.alt), 64'(want.alt));
    if (got.seconds !== want.seconds)
      flag_mismatch("utc_seconds", 64'(got.seconds), 64'(want.seconds));
    if (got.pps_latest !== want.pps_latest)
      flag_mismatch("pps_latest", 64'(got.pps_latest), 64'(want.pps_latest));
    if (got.pps_prev !== want.pps_prev)
      flag_mismatch("pps_previous", 64'(got.pps_prev), 64'(want.pps_prev));
  endtask

  // Driver: one report per transaction, a random gap before each, with calm
  // stretches where reports follow back to back.
  int unsigned src_gap  = 0;
  logic        src_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        fix_result_q.push_back(track_fix(gnss_report_t'(s_axis_tdata)));
        busy = 1'b0;
      end
      if (!busy) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (report_q.size() > 0) begin
          s_axis_tdata <= report_q.pop_front();
          busy = 1'b1;
          if ($urandom_range(0, 31) == 0) src_calm = ~src_calm;
          src_gap = src_calm ? 0 : $urandom_range(0, MAX_WAIT);
        end
      end
      s_axis_tvalid <= busy;
    end
  end

  // Monitor: checks each result transaction and stalls at random after it.
  int unsigned sink_gap  = 0;
  logic        sink_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (fix_result_q.size() == 0) begin
          flag_mismatch("unexpected result", m_axis_tdata[63:0], '0);
        end else begin
          check_result(fix_result_t'(m_axis_tdata), fix_result_q.pop_front());
        end
        if ($urandom_range(0, 31) == 0) sink_calm = ~sink_calm;
        sink_gap = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic gnss_report_t fix_item(input logic fix, input logic hold,
                                            input logic [3:0] month,
                                            input logic [4:0] day,
                                            input logic [4:0] hour,
                                            input logic [5:0] minute,
                                            input logic [15:0] msec);
    gnss_report_t it;
    logic [63:0] r;
    it = '0;
    it.fix    = fix;
    it.hold   = hold;
    r = {$urandom(), $urandom()};
    it.lon    = r[38:0];
    r = {$urandom(), $urandom()};
    it.lat    = r[37:0];
    it.alt    = $urandom();
    it.month  = month;
    it.day    = day;
    it.hour   = hour;
    it.minute = minute;
    it.msec   = msec;
    it.pps    = $urandom();
    return it;
  endfunction

  // Mostly calendar values in range, with some out-of-range field values.
  function automatic gnss_report_t rand_item();
    logic       wild;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [15:0] msec;
    wild   = ($urandom_range(0, 7) == 0);
    month  = wild ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
    day    = wild ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 31));
    hour   = wild ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
    minute = wild ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
    msec   = wild ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 60999));
    return fix_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), month, day,
                    hour, minute, msec);
  endfunction

  // Sampled on the falling edge, after the driver and monitor have settled.
  task automatic drain();
    while (report_q.size() != 0 || s_axis_tvalid || fix_result_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == gfts_pkg::CFG_BASE_SECONDS) trk_base_secs = data;
    else if (idx == gfts_pkg::CFG_BASE_MONTH) trk_base_mon = data[3:0];
    cfg_valid_i <= 1'b0;
  endtask

  logic [31:0] phase_secs [7];
  logic [31:0] phase_mon  [7];

  initial begin
    gnss_report_t held;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the mode sequence; the hold flag is ignored until sampling.
    report_q.push_back(fix_item(1'b0, 1'b0, 4'd8, 5'd1, 5'd0, 6'd0, 16'd0));
    report_q.push_back(fix_item(1'b0, 1'b1, 4'd8, 5'd1, 5'd0, 6'd0, 16'd0));
    report_q.push_back(fix_item(1'b1, 1'b0, 4'd8, 5'd1, 5'd0, 6'd0, 16'd0));
    report_q.push_back(fix_item(1'b0, 1'b0, 4'd8, 5'd1, 5'd0, 6'd0, 16'd0));
    held = fix_item(1'b1, 1'b1, 4'd8, 5'd1, 5'd0, 6'd0, 16'd0);
    held.lon = -39'sd180_000_000_000;
    held.lat = 38'sd90_000_000_000;
    held.alt = 32'h8000_0000;
    report_q.push_back(held);

    // Timestamp corner cases under the reset configuration.
    report_q.push_back(fix_item(1'b1, 1'b0, 4'd8, 5'd1, 5'd0, 6'd0, 16'd0));
    report_q.push_back(fix_item(1'b1, 1'b1, 4'd12, 5'd31, 5'd23, 6'd59, 16'd60999));
    report_q.push_back(fix_item(1'b0, 1'b0, 4'd1, 5'd15, 5'd12, 6'd30, 16'd30500));
    report_q.push_back(fix_item(1'b1, 1'b0, 4'd0, 5'd1, 5'd0, 6'd0, 16'd0));
    report_q.push_back(fix_item(1'b1, 1'b0, 4'd13, 5'd1, 5'd0, 6'd0, 16'd0));
    report_q.push_back(fix_item(1'b1, 1'b0, 4'd15, 5'd31, 5'd0, 6'd0, 16'd999));
    report_q.push_back(fix_item(1'b1, 1'b0, 4'd9, 5'd0, 5'd0, 6'd0, 16'd0));
    report_q.push_back(fix_item(1'b1, 1'b0, 4'd10, 5'd31, 5'd31, 6'd63, 16'd65535));
    report_q.push_back(fix_item(1'b0, 1'b1, 4'd11, 5'd2, 5'd1, 6'd1, 16'd1000));
    report_q.push_back(fix_item(1'b1, 1'b0, 4'd8, 5'd31, 5'd23, 6'd59, 16'd59999));
    drain();

    phase_secs = '{32'd0, 32'hFFFF_FFFF, $urandom(), $urandom(), $urandom(),
                   $urandom(), gfts_pkg::RESET_BASE_SECONDS};
    phase_mon  = '{32'd1, 32'd12, 32'd0, 32'd15, 32'($urandom_range(1, 12)),
                   $urandom(), 32'(gfts_pkg::RESET_BASE_MONTH)};

    for (int p = 0; p < 7; p++) begin
      write_reg(gfts_pkg::CFG_BASE_SECONDS, phase_secs[p]);
      write_reg(gfts_pkg::CFG_BASE_MONTH, phase_mon[p]);
      // Writes to the spare indexes must leave both registers alone.
      if (p == 3) begin
        write_reg(CFG_SPARE_A, $urandom());
        write_reg(CFG_SPARE_B, $urandom());
      end
      for (int i = 0; i < PHASE_ITEMS; i++) report_q.push_back(rand_item());
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("gnss_fix_tracker_utc_stamper regression: pass");
    end else begin
      $display("gnss_fix_tracker_utc_stamper regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("gnss_fix_tracker_utc_stamper regression: fail");
    $finish;
  end

endmodule
